[rtl/jfhs_pkg.sv]
// Package for the JPEG frame header scanner: parse phases, status codes, marker constants.
`default_nettype none

package jfhs_pkg;

  // Parse phase of the byte scanner
  typedef enum logic [3:0] {
    PH_SOI0   = 4'd0,
    PH_SOI1   = 4'd1,
    PH_SCAN   = 4'd2,
    PH_MARK   = 4'd3,
    PH_SOF_LH = 4'd4,
    PH_SOF_LL = 4'd5,
    PH_SOF_P  = 4'd6,
    PH_SOF_HH = 4'd7,
    PH_SOF_HL = 4'd8,
    PH_SOF_WH = 4'd9,
    PH_SOF_WL = 4'd10,
    PH_SOF_NC = 4'd11,
    PH_SEG_LH = 4'd12,
    PH_SEG_LL = 4'd13,
    PH_SKIP   = 4'd14
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_SHORT   = 2'd1,
    ST_CORRUPT = 2'd2
  } status_t;

  // Outcome of a marker code byte
  typedef struct packed {
    phase_t phase;
    logic   corrupt;
  } mark_res_t;

  localparam logic [7:0]  MK_PREFIX    = 8'hff;
  localparam logic [7:0]  MK_SOI       = 8'hd8;
  localparam logic [7:0]  MK_RST_MASK  = 8'hf8;
  localparam logic [7:0]  MK_RST_BASE  = 8'hd0;
  localparam logic [7:0]  MK_EOI       = 8'hd9;
  localparam logic [7:0]  MK_SOF0      = 8'hc0;
  localparam logic [7:0]  MK_SOF1      = 8'hc1;
  localparam logic [7:0]  MK_SOS       = 8'hda;
  localparam logic [7:0]  MK_STUFF_MAX = 8'h01;
  localparam logic [7:0]  PREC_8       = 8'd8;
  localparam logic [7:0]  PREC_12      = 8'd12;
  localparam logic [31:0] MIN_BUF_LEN  = 32'd10;
  localparam logic [15:0] SOF_MIN_LEN  = 16'd11;

endpackage

`default_nettype wire

[rtl/jpeg_frame_header_scanner.sv]
// Top level of the JPEG frame header scanner: byte parser with registered result.
//
// Usage: load cfg_wr_data through cfg_wr_en with the byte count of the next
// buffer while the block is idle, then stream the buffer one byte per
// transaction on the in_ channel (in_last_byte marks the final byte). The
// block gives one transaction on the out_ channel per buffer: header found
// with height, width, components and precision, buffer too small, or corrupt.
// Bytes after the result, up to the buffer end, are consumed and dropped.
// Throughput: one byte per cycle; the parse step, including a two-byte
// replay of SOF length bytes, is done in the same cycle as the byte.
// The result is in the output register in the cycle after the byte
// that decides it. The output register frees the input side: a new byte is
// taken while the register is empty or being read in the same cycle. When
// the receiver stalls with a result pending, in_ready drops until it is read.
// Reset (rst_n low, synchronous) clears the buffer length to zero, the scan
// state to the start of a buffer and empties the output register.
`default_nettype none

module jpeg_frame_header_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_height,
  output logic [15:0]      out_width,
  output logic [7:0]       out_components,
  output logic             out_twelve_bit
);

  // State registers
  logic [31:0]          buf_len_r;
  logic [31:0]          pos_r, pos_nxt;
  jfhs_pkg::phase_t     phase_r, phase_nxt;
  logic [15:0]          skip_r, skip_nxt;
  logic [15:0]          seg_len_r, seg_len_nxt;
  logic [7:0]           rep0_r, rep0_nxt;
  logic [15:0]          height_r, height_nxt;
  logic [15:0]          width_r, width_nxt;
  logic                 done_r, done_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  jfhs_pkg::status_t    out_status_r, out_status_nxt;
  logic [15:0]          out_height_r, out_height_nxt;
  logic [15:0]          out_width_r, out_width_nxt;
  logic [7:0]           out_comp_r, out_comp_nxt;
  logic                 out_twelve_r, out_twelve_nxt;

  logic                 in_fire;
  logic                 buf_end;
  logic                 ev_valid;
  jfhs_pkg::status_t    ev_status;
  logic                 ev_twelve;
  jfhs_pkg::phase_t     step_phase;
  logic [15:0]          sz;
  logic [9:0]           comp_len;
  jfhs_pkg::mark_res_t  mk;

  // Marker code handling after a 0xff prefix
  function automatic jfhs_pkg::mark_res_t mark_step(input logic [7:0] b,
                                                    input logic [31:0] pos,
                                                    input logic [31:0] len);
    jfhs_pkg::mark_res_t r;
    r.phase   = jfhs_pkg::PH_SCAN;
    r.corrupt = 1'b0;
    if (((b & jfhs_pkg::MK_RST_MASK) == jfhs_pkg::MK_RST_BASE) ||
        (b == jfhs_pkg::MK_EOI) || (b <= jfhs_pkg::MK_STUFF_MAX)) begin
      r.phase = jfhs_pkg::PH_SCAN;
    end else if ((b == jfhs_pkg::MK_SOF0) || (b == jfhs_pkg::MK_SOF1)) begin
      r.phase = (({2'b0, pos} + 34'd2) >= {2'b0, len}) ? jfhs_pkg::PH_SCAN
                                                       : jfhs_pkg::PH_SOF_LH;
    end else if (b == jfhs_pkg::MK_SOS) begin
      r.corrupt = 1'b1;
    end else begin
      r.phase = (({2'b0, pos} + 34'd3) >= {2'b0, len}) ? jfhs_pkg::PH_SCAN
                                                       : jfhs_pkg::PH_SEG_LH;
    end
    return r;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign buf_end  = in_last_byte || (({1'b0, pos_r} + 33'd1) >= {1'b0, buf_len_r});
  assign sz       = {rep0_r, in_data_byte};
  assign comp_len = {in_data_byte, 1'b0} + {2'b0, in_data_byte} + 10'd8;
  assign mk       = mark_step(in_data_byte, pos_r, buf_len_r);

  // Parse step for one byte, including replay of SOF length bytes
  always_comb begin
    step_phase  = phase_r;
    skip_nxt    = skip_r;
    seg_len_nxt = seg_len_r;
    rep0_nxt    = rep0_r;
    height_nxt  = height_r;
    width_nxt   = width_r;
    ev_valid    = 1'b0;
    ev_status   = jfhs_pkg::ST_CORRUPT;
    ev_twelve   = 1'b0;
    case (phase_r)
      jfhs_pkg::PH_SOI0: begin
        if (buf_len_r < jfhs_pkg::MIN_BUF_LEN) begin
          ev_valid  = 1'b1;
          ev_status = jfhs_pkg::ST_SHORT;
        end else if (in_data_byte != jfhs_pkg::MK_PREFIX) begin
          ev_valid = 1'b1;
        end else begin
          step_phase = jfhs_pkg::PH_SOI1;
        end
      end
      jfhs_pkg::PH_SOI1: begin
        if (in_data_byte != jfhs_pkg::MK_SOI) ev_valid = 1'b1;
        else step_phase = jfhs_pkg::PH_SCAN;
      end
      jfhs_pkg::PH_SCAN: begin
        if (in_data_byte == jfhs_pkg::MK_PREFIX) step_phase = jfhs_pkg::PH_MARK;
      end
      jfhs_pkg::PH_MARK: begin
        step_phase = mk.phase;
        ev_valid   = mk.corrupt;
      end
      jfhs_pkg::PH_SOF_LH: begin
        rep0_nxt   = in_data_byte;
        step_phase = jfhs_pkg::PH_SOF_LL;
      end
      jfhs_pkg::PH_SOF_LL: begin
        seg_len_nxt = sz;
        if (({2'b0, pos_r} + {18'b0, sz}) >= ({2'b0, buf_len_r} + 34'd1)) begin
          // Segment runs past the end: rescan both length bytes
          if (rep0_r == jfhs_pkg::MK_PREFIX) begin
            step_phase = mk.phase;
            ev_valid   = mk.corrupt;
          end else begin
            step_phase = (in_data_byte == jfhs_pkg::MK_PREFIX) ? jfhs_pkg::PH_MARK
                                                              : jfhs_pkg::PH_SCAN;
          end
        end else if (sz < jfhs_pkg::SOF_MIN_LEN) begin
          ev_valid = 1'b1;
        end else begin
          step_phase = jfhs_pkg::PH_SOF_P;
        end
      end
      jfhs_pkg::PH_SOF_P: begin
        rep0_nxt   = in_data_byte;
        step_phase = jfhs_pkg::PH_SOF_HH;
      end
      jfhs_pkg::PH_SOF_HH: begin
        height_nxt = {in_data_byte, 8'h00};
        step_phase = jfhs_pkg::PH_SOF_HL;
      end
      jfhs_pkg::PH_SOF_HL: begin
        height_nxt = {height_r[15:8], in_data_byte};
        step_phase = jfhs_pkg::PH_SOF_WH;
      end
      jfhs_pkg::PH_SOF_WH: begin
        width_nxt  = {in_data_byte, 8'h00};
        step_phase = jfhs_pkg::PH_SOF_WL;
      end
      jfhs_pkg::PH_SOF_WL: begin
        width_nxt  = {width_r[15:8], in_data_byte};
        step_phase = jfhs_pkg::PH_SOF_NC;
      end
      jfhs_pkg::PH_SOF_NC: begin
        ev_valid = 1'b1;
        if ((comp_len == seg_len_r[9:0]) && (seg_len_r[15:10] == 6'd0) &&
            ((rep0_r == jfhs_pkg::PREC_8) || (rep0_r == jfhs_pkg::PREC_12))) begin
          ev_status = jfhs_pkg::ST_FOUND;
          ev_twelve = (rep0_r == jfhs_pkg::PREC_12);
        end
      end
      jfhs_pkg::PH_SEG_LH: begin
        rep0_nxt   = in_data_byte;
        step_phase = jfhs_pkg::PH_SEG_LL;
      end
      jfhs_pkg::PH_SEG_LL: begin
        // Lengths 0..2 replay bytes that leave the scan where it is
        seg_len_nxt = sz;
        step_phase  = jfhs_pkg::PH_SCAN;
        if (sz > 16'd2) begin
          skip_nxt   = sz - 16'd2;
          step_phase = jfhs_pkg::PH_SKIP;
        end
      end
      jfhs_pkg::PH_SKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) step_phase = jfhs_pkg::PH_SCAN;
      end
      default: begin
        step_phase = jfhs_pkg::PH_SCAN;
      end
    endcase
  end

  // Buffer bookkeeping and result capture
  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_height_nxt = out_height_r;
    out_width_nxt  = out_width_r;
    out_comp_nxt   = out_comp_r;
    out_twelve_nxt = out_twelve_r;
    if (in_fire) begin
      if (!done_r) begin
        phase_nxt = step_phase;
        if (ev_valid || buf_end) begin
          done_nxt       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ev_valid ? ev_status : jfhs_pkg::ST_SHORT;
          if (ev_valid && (ev_status == jfhs_pkg::ST_FOUND)) begin
            out_height_nxt = height_r;
            out_width_nxt  = width_r;
            out_comp_nxt   = in_data_byte;
            out_twelve_nxt = ev_twelve;
          end else begin
            out_height_nxt = 16'd0;
            out_width_nxt  = 16'd0;
            out_comp_nxt   = 8'd0;
            out_twelve_nxt = 1'b0;
          end
        end
      end
      if (buf_end) begin
        pos_nxt   = 32'd0;
        phase_nxt = jfhs_pkg::PH_SOI0;
        done_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_r + 32'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= 32'd0;
      pos_r       <= 32'd0;
      phase_r     <= jfhs_pkg::PH_SOI0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) buf_len_r <= cfg_wr_data;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire && !done_r) begin
      skip_r    <= skip_nxt;
      seg_len_r <= seg_len_nxt;
      rep0_r    <= rep0_nxt;
      height_r  <= height_nxt;
      width_r   <= width_nxt;
    end
    out_status_r <= out_status_nxt;
    out_height_r <= out_height_nxt;
    out_width_r  <= out_width_nxt;
    out_comp_r   <= out_comp_nxt;
    out_twelve_r <= out_twelve_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_height     = out_height_r;
  assign out_width      = out_width_r;
  assign out_components = out_comp_r;
  assign out_twelve_bit = out_twelve_r;

endmodule

`default_nettype wire

[test/jpeg_frame_header_scanner_test.sv]
// Testbench for the JPEG frame header scanner: random byte buffers checked against a predictor.
`timescale 1ns / 100ps

// Outcome of scanning one byte: a status, nothing yet, or a replay of held length bytes
typedef enum logic [2:0] {
  STEP_FOUND       = 3'd0,
  STEP_SHORT       = 3'd1,
  STEP_CORRUPT     = 3'd2,
  STEP_QUIET       = 3'd3,
  STEP_REPLAY_BOTH = 3'd4,
  STEP_REPLAY_LAST = 3'd5
} step_event_t;

typedef struct packed {
  jfhs_pkg::status_t status;
  logic [15:0]       height;
  logic [15:0]       width;
  logic [7:0]        components;
  logic              twelve_bit;
} frame_report_t;

// Tracks the scanner state per byte and checks each result transaction in order
class frame_header_scoreboard;
  logic [31:0]      buf_len;
  logic [31:0]      position;
  jfhs_pkg::phase_t phase;
  logic [15:0]      skip_left;
  logic [15:0]      seg_len;
  logic [7:0]       held [2];
  logic [15:0]      rows;
  logic [15:0]      cols;
  logic [7:0]       comp_count;
  logic             twelve;
  logic             done;
  frame_report_t    expected_reports[$];
  int               mismatches;

  function new();
    buf_len = '0;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    position = '0;
    phase = jfhs_pkg::PH_SOI0;
    skip_left = '0;
    seg_len = '0;
    held[0] = '0;
    held[1] = '0;
    rows = '0;
    cols = '0;
    comp_count = '0;
    twelve = 1'b0;
    done = 1'b0;
  endfunction

  function void set_length(logic [31:0] value);
    buf_len = value;
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  // One byte through the parse phases at buffer position pos
  function step_event_t scan_byte(logic [7:0] b, longint unsigned pos);
    longint unsigned len;
    logic [15:0] sz;
    len = buf_len;
    case (phase)
      jfhs_pkg::PH_SOI0: begin
        if (len < jfhs_pkg::MIN_BUF_LEN) return STEP_SHORT;
        if (b != jfhs_pkg::MK_PREFIX) return STEP_CORRUPT;
        phase = jfhs_pkg::PH_SOI1;
      end
      jfhs_pkg::PH_SOI1: begin
        if (b != jfhs_pkg::MK_SOI) return STEP_CORRUPT;
        phase = jfhs_pkg::PH_SCAN;
      end
      jfhs_pkg::PH_SCAN: begin
        if (b == jfhs_pkg::MK_PREFIX) phase = jfhs_pkg::PH_MARK;
      end
      jfhs_pkg::PH_MARK: begin
        // lengthless codes, frame header, scan start, then any other segment
        if ((b & jfhs_pkg::MK_RST_MASK) == jfhs_pkg::MK_RST_BASE ||
            b == jfhs_pkg::MK_EOI || b <= jfhs_pkg::MK_STUFF_MAX)
          phase = jfhs_pkg::PH_SCAN;
        else if (b == jfhs_pkg::MK_SOF0 || b == jfhs_pkg::MK_SOF1)
          phase = (pos + 2 >= len) ? jfhs_pkg::PH_SCAN : jfhs_pkg::PH_SOF_LH;
        else if (b == jfhs_pkg::MK_SOS)
          return STEP_CORRUPT;
        else
          phase = (pos + 3 >= len) ? jfhs_pkg::PH_SCAN : jfhs_pkg::PH_SEG_LH;
      end
      jfhs_pkg::PH_SOF_LH: begin
        held[0] = b;
        phase = jfhs_pkg::PH_SOF_LL;
      end
      jfhs_pkg::PH_SOF_LL: begin
        held[1] = b;
        sz = {held[0], b};
        seg_len = sz;
        // frame header running into the buffer end: rescan its length bytes
        if (pos - 1 + sz >= len) begin
          phase = jfhs_pkg::PH_SCAN;
          return STEP_REPLAY_BOTH;
        end
        if (sz < jfhs_pkg::SOF_MIN_LEN) return STEP_CORRUPT;
        phase = jfhs_pkg::PH_SOF_P;
      end
      jfhs_pkg::PH_SOF_P: begin
        held[0] = b;
        phase = jfhs_pkg::PH_SOF_HH;
      end
      jfhs_pkg::PH_SOF_HH: begin
        rows = {b, 8'h00};
        phase = jfhs_pkg::PH_SOF_HL;
      end
      jfhs_pkg::PH_SOF_HL: begin
        rows[7:0] = b;
        phase = jfhs_pkg::PH_SOF_WH;
      end
      jfhs_pkg::PH_SOF_WH: begin
        cols = {b, 8'h00};
        phase = jfhs_pkg::PH_SOF_WL;
      end
      jfhs_pkg::PH_SOF_WL: begin
        cols[7:0] = b;
        phase = jfhs_pkg::PH_SOF_NC;
      end
      jfhs_pkg::PH_SOF_NC: begin
        if (32'(b) * 3 + 8 != 32'(seg_len)) return STEP_CORRUPT;
        if (held[0] != jfhs_pkg::PREC_8 && held[0] != jfhs_pkg::PREC_12) return STEP_CORRUPT;
        twelve = (held[0] == jfhs_pkg::PREC_12);
        comp_count = b;
        return STEP_FOUND;
      end
      jfhs_pkg::PH_SEG_LH: begin
        held[0] = b;
        phase = jfhs_pkg::PH_SEG_LL;
      end
      jfhs_pkg::PH_SEG_LL: begin
        held[1] = b;
        sz = {held[0], b};
        seg_len = sz;
        phase = jfhs_pkg::PH_SCAN;
        if (sz == 0) return STEP_REPLAY_BOTH;
        if (sz == 1) return STEP_REPLAY_LAST;
        if (sz > 2) begin
          skip_left = sz - 2;
          phase = jfhs_pkg::PH_SKIP;
        end
      end
      jfhs_pkg::PH_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = jfhs_pkg::PH_SCAN;
      end
      default: phase = jfhs_pkg::PH_SCAN;
    endcase
    return STEP_QUIET;
  endfunction

  // Accepted input transaction: advance the state, queue a result if one is due
  function void note_byte(logic [7:0] value, logic last);
    longint unsigned pos;
    longint unsigned len;
    step_event_t     ev;
    logic [7:0]      second;
    frame_report_t   res;
    pos = position;
    len = buf_len;
    ev = STEP_QUIET;
    if (!done) begin
      ev = scan_byte(value, pos);
      if (ev == STEP_REPLAY_BOTH) begin
        second = held[1];
        ev = scan_byte(held[0], pos - 1);
        if (ev >= STEP_QUIET) ev = scan_byte(second, pos);
      end else if (ev == STEP_REPLAY_LAST) begin
        ev = scan_byte(held[1], pos);
      end
      if (ev >= STEP_QUIET && (last || pos + 1 >= len)) ev = STEP_SHORT;
      if (ev < STEP_QUIET) begin
        res = '0;
        res.status = jfhs_pkg::status_t'(ev[1:0]);
        if (ev == STEP_FOUND) begin
          res.height = rows;
          res.width = cols;
          res.components = comp_count;
          res.twelve_bit = twelve;
        end
        expected_reports.push_back(res);
        done = 1'b1;
      end
    end
    if (last || pos + 1 >= len) restart();
    else position = 32'(pos + 1);
  endfunction

  // Result transaction against the oldest expectation
  function void check_result(frame_report_t got);
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status %0d rows %0d cols %0d comps %0d 12b %0b",
                 $time, got.status, got.height, got.width, got.components, got.twelve_bit);
      return;
    end
    want = expected_reports.pop_front();
    if (got.status !== want.status || got.height !== want.height ||
        got.width !== want.width || got.components !== want.components ||
        got.twelve_bit !== want.twelve_bit) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: expected status %0d rows %0d cols %0d comps %0d 12b %0b", $time,
                 want.status, want.height, want.width, want.components, want.twelve_bit);
        $display("%0t:      got status %0d rows %0d cols %0d comps %0d 12b %0b", $time,
                 got.status, got.height, got.width, got.components, got.twelve_bit);
      end
    end
  endfunction
endclass

module jpeg_frame_header_scanner_test;

  localparam int IDLE_LIMIT = 1000;
  localparam int BYTE_TARGET = 1300;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_height;
  logic [15:0] out_width;
  logic [7:0]  out_components;
  logic        out_twelve_bit;

  frame_header_scoreboard sb;

  logic [7:0]  frame_bytes[$];
  logic        frame_last[$];
  logic        length_loaded = 1'b0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] ready_pattern;
  int          pattern_age = 0;

  jpeg_frame_header_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_height     (out_height),
    .out_width      (out_width),
    .out_components (out_components),
    .out_twelve_bit (out_twelve_bit)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: ready follows a rotating 16-bit pattern, reloaded with a new shape each time it runs out
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age = 16;
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'h0001;
        default: ready_pattern = 16'($urandom);
      endcase
    end
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age--;
  end

  // Result monitor: a transaction completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(frame_report_t'({out_status, out_height, out_width,
                                       out_components, out_twelve_bit}));
  end

  // Watchdog on cycles without any transaction
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles < IDLE_LIMIT) begin
      quiet_cycles++;
    end else begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] value);
    frame_bytes.push_back(value);
    frame_last.push_back(1'b0);
  endfunction

  function automatic void mark_last();
    frame_last[frame_last.size() - 1] = 1'b1;
  endfunction

  // Frame header up to and including the component count
  function automatic void push_sof(logic [7:0] code, logic [15:0] seg, logic [7:0] prec,
                                   logic [15:0] rows, logic [15:0] cols, logic [7:0] ncomp);
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(code);
    push_byte(seg[15:8]);
    push_byte(seg[7:0]);
    push_byte(prec);
    push_byte(rows[15:8]);
    push_byte(rows[7:0]);
    push_byte(cols[15:8]);
    push_byte(cols[7:0]);
    push_byte(ncomp);
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Marker code of a length-prefixed segment that is neither a frame header nor SOS
  function automatic logic [7:0] segment_code();
    logic [7:0] code;
    code = 8'($urandom_range(2, 254));
    if ((code & jfhs_pkg::MK_RST_MASK) == jfhs_pkg::MK_RST_BASE ||
        code == jfhs_pkg::MK_EOI || code == jfhs_pkg::MK_SOF0 ||
        code == jfhs_pkg::MK_SOF1 || code == jfhs_pkg::MK_SOS)
      code = 8'he0 | (code & 8'h0f);
    return code;
  endfunction

  // One input transaction, possibly preceded by an idle gap at the start of each burst
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= last;
    do @(negedge clk); while (!in_ready);
    sb.note_byte(value, last);
    bytes_sent++;
    @(posedge clk);
  endtask

  // Load the length register if it changes (block drained first), then stream the buffer
  task automatic run_buffer(input logic [31:0] length_value);
    if (!length_loaded || length_value != sb.buf_len) begin
      in_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= length_value;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      sb.set_length(length_value);
      length_loaded = 1'b1;
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], frame_last[i]);
    frame_bytes.delete();
    frame_last.delete();
  endtask

  // Mostly well-formed buffers with random content, some noise and broken headers
  task automatic random_buffer();
    int          kind;
    int          sel;
    int          n;
    logic [7:0]  ncomp;
    logic [7:0]  prec;
    logic [15:0] seg;
    logic [31:0] length_value;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(2, 30);
      repeat (n) push_byte(8'($urandom));
      if ($urandom_range(0, 1)) begin
        frame_bytes[0] = jfhs_pkg::MK_PREFIX;
        frame_bytes[1] = jfhs_pkg::MK_SOI;
      end
      foreach (frame_last[i]) frame_last[i] = ($urandom_range(0, 11) == 0);
    end else begin
      push_byte(jfhs_pkg::MK_PREFIX);
      push_byte(jfhs_pkg::MK_SOI);
      if (kind == 1) frame_bytes[$urandom_range(0, 1)] = 8'($urandom);
      repeat ($urandom_range(0, 4)) begin
        sel = $urandom_range(0, 5);
        case (sel)
          0: repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 254)));
          1: begin
            push_byte(jfhs_pkg::MK_PREFIX);
            case ($urandom_range(0, 3))
              0: push_byte(8'h00);
              1: push_byte(jfhs_pkg::MK_STUFF_MAX);
              2: push_byte(jfhs_pkg::MK_RST_BASE | 8'($urandom_range(0, 7)));
              default: push_byte(jfhs_pkg::MK_EOI);
            endcase
          end
          2: begin
            // segment length of 0, 1 or 2
            push_byte(jfhs_pkg::MK_PREFIX);
            push_byte(segment_code());
            push_byte(8'h00);
            push_byte(8'($urandom_range(0, 2)));
          end
          default: begin
            // segment with a body; fill byte as marker code on sel 4
            n = $urandom_range(3, 10);
            push_byte(jfhs_pkg::MK_PREFIX);
            push_byte((sel == 4) ? jfhs_pkg::MK_PREFIX : segment_code());
            if ($urandom_range(0, 7) == 0) begin
              push_byte(8'($urandom));
              push_byte(8'($urandom));
            end else begin
              push_byte(8'h00);
              push_byte(8'(n));
              repeat (n - 2) push_byte(8'($urandom));
            end
          end
        endcase
      end
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        push_byte(jfhs_pkg::MK_PREFIX);
        push_byte(jfhs_pkg::MK_SOS);
      end else if (sel <= 6) begin
        ncomp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
        seg = 16'(8 + 3 * int'(ncomp));
        prec = $urandom_range(0, 1) ? jfhs_pkg::PREC_12 : jfhs_pkg::PREC_8;
        // broken header: short length, length off the component count, odd precision
        if (sel == 6) begin
          case ($urandom_range(0, 2))
            0: seg = 16'($urandom_range(0, 10));
            1: seg = seg + 16'($urandom_range(1, 3));
            default: prec = 8'($urandom);
          endcase
        end
        push_sof($urandom_range(0, 1) ? jfhs_pkg::MK_SOF1 : jfhs_pkg::MK_SOF0, seg, prec,
                 pick_dim(), pick_dim(), ncomp);
        if (ncomp <= 4) repeat (3 * ncomp) push_byte(8'($urandom));
      end
      if ($urandom_range(0, 3) != 0) begin
        push_byte(jfhs_pkg::MK_PREFIX);
        push_byte(jfhs_pkg::MK_EOI);
      end
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    end
    // buffer length: exact, unbounded, below minimum, truncating, or longer than sent
    n = frame_bytes.size();
    sel = $urandom_range(0, 9);
    if (sel <= 4) begin
      length_value = 32'(n);
      if ($urandom_range(0, 1)) mark_last();
    end else begin
      if (sel <= 6) length_value = '1;
      else if (sel == 7) length_value = 32'($urandom_range(0, 9));
      else if (sel == 8) length_value = 32'($urandom_range(2, n));
      else length_value = 32'(n + $urandom_range(1, 20));
      mark_last();
    end
    run_buffer(length_value);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero length: too small at the first byte
    push_byte(8'h00);
    run_buffer(32'd0);
    // one below the minimum length
    push_byte(jfhs_pkg::MK_PREFIX);
    mark_last();
    run_buffer(32'd9);
    // bad second SOI byte, unbounded length
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(8'h00);
    mark_last();
    run_buffer('1);
    // RST and stuffed codes skipped, then a 12-bit frame header with extreme sizes
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_SOI);
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_RST_BASE);
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_STUFF_MAX);
    push_sof(jfhs_pkg::MK_SOF1, 16'd17, jfhs_pkg::PREC_12, 16'hffff, 16'h0000, 8'd3);
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_EOI);
    mark_last();
    run_buffer('1);
    // scan start before any frame header
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_SOI);
    push_byte(jfhs_pkg::MK_PREFIX);
    push_byte(jfhs_pkg::MK_SOS);
    mark_last();
    run_buffer(32'd12);

    while (bytes_sent < BYTE_TARGET) random_buffer();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[jpeg_frame_header_scanner.f]
rtl/jfhs_pkg.sv
rtl/jpeg_frame_header_scanner.sv
test/jpeg_frame_header_scanner_test.sv
